// ===== design/landsat_dn_to_toa_unit_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the TOA conversion unit
// Shared concurrent assertion forms, clocked on clk and held off in reset.
// ---------------------------------------------------------------------------
`ifndef LANDSAT_DN_TO_TOA_UNIT_MACROS_SVH
`define LANDSAT_DN_TO_TOA_UNIT_MACROS_SVH

// Same-cycle implication.
`define LDT_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Implication after a fixed number of cycles.
`define LDT_ASSERT_DLY(lbl, ante, dly, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> ##dly (cons)) \
		else $error(msg);

`endif

// ===== design/ldt_pkg.sv =====
// ---------------------------------------------------------------------------
// ldt_pkg
// Shared constants, codes and sideband types of the TOA conversion unit.
// ---------------------------------------------------------------------------
package ldt_pkg;

	// Default parameter values.
	localparam int DN_BITS_DEF       = 16;
	localparam int FRACTION_BITS_DEF = 16;

	// Configuration port geometry.
	localparam int CFG_W = 32;
	localparam int IDX_W = 3;
	localparam int K_W   = 31;

	typedef logic [IDX_W-1:0] reg_idx_t;
	localparam reg_idx_t REG_GAIN  = 3'd0;
	localparam reg_idx_t REG_BIAS  = 3'd1;
	localparam reg_idx_t REG_K_ONE = 3'd2;
	localparam reg_idx_t REG_K_TWO = 3'd3;
	localparam reg_idx_t REG_MODE  = 3'd4;

	// Result status codes.
	typedef logic [1:0] status_t;
	localparam status_t STATUS_OK       = 2'd0;
	localparam status_t STATUS_NONPOS   = 2'd1;
	localparam status_t STATUS_ZERO_DIV = 2'd2;

	// Saturation limits of the 32-bit results.
	localparam logic signed [31:0] SAT_MAX = 32'sh7fffffff;
	localparam logic signed [31:0] SAT_MIN = 32'sh80000000;

	// ln(2) in Q0.32 and number of squaring steps of the log2 fraction.
	localparam logic [31:0] LN2_Q32   = 32'd2977044472;
	localparam int          LOG_STEPS = 32;

	// Sideband carried next to the first divider.
	typedef struct packed {
		logic signed [31:0] rad;
		status_t            status;
		logic               neg;
	} div1_side_t;

	// Sideband carried through the log unit.
	typedef struct packed {
		logic signed [31:0] rad;
		status_t            status;
		logic signed [31:0] refl;
	} log_side_t;

	// Sideband carried next to the second divider.
	typedef struct packed {
		log_side_t base;
		logic      ln_zero;
	} div2_side_t;

	// Cycles from an accepted request to its result strobe.
	function automatic int ldt_latency(input int frac_bits);
		int w1;
		w1 = 32 + frac_bits;
		return w1 + (31 + frac_bits) + $clog2(w1) + 37;
	endfunction

endpackage

// ===== design/ldt_div.sv =====
// ---------------------------------------------------------------------------
// ldt_div
// Pipelined restoring divider: one quotient bit per stage, unsigned.
// ---------------------------------------------------------------------------
module ldt_div #(
	parameter int NUM_W  = 48,
	parameter int DEN_W  = 31,
	parameter int SIDE_W = 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic [NUM_W-1:0]  in_num,
	input  logic [DEN_W-1:0]  in_den,
	input  logic [SIDE_W-1:0] in_side,
	output logic              out_valid,
	output logic [NUM_W-1:0]  out_quo,
	output logic [SIDE_W-1:0] out_side
);

	logic              vld_s  [NUM_W];
	logic [DEN_W-1:0]  rem_s  [NUM_W];
	logic [NUM_W-1:0]  wrk_s  [NUM_W];
	logic [DEN_W-1:0]  den_s  [NUM_W];
	logic [SIDE_W-1:0] side_s [NUM_W];

	for (genvar i = 0; i < NUM_W; i++) begin : g_stage
		logic              p_vld;
		logic [DEN_W-1:0]  p_rem;
		logic [DEN_W-1:0]  p_den;
		logic [NUM_W-1:0]  p_wrk;
		logic [SIDE_W-1:0] p_side;
		logic [DEN_W:0]    trial;
		logic              take;

		// Stage input: the ports for the first stage, the previous stage otherwise.
		if (i == 0) begin : g_first
			assign p_vld  = in_valid;
			assign p_rem  = '0;
			assign p_den  = in_den;
			assign p_wrk  = in_num;
			assign p_side = in_side;
		end else begin : g_next
			assign p_vld  = vld_s[i-1];
			assign p_rem  = rem_s[i-1];
			assign p_den  = den_s[i-1];
			assign p_wrk  = wrk_s[i-1];
			assign p_side = side_s[i-1];
		end

		// Bring down the next numerator bit and try the subtraction.
		assign trial = {p_rem, p_wrk[NUM_W-1]};
		assign take  = (trial >= {1'b0, p_den});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i] <= 1'b0;
			end else begin
				vld_s[i] <= p_vld;
			end
		end

		// Quotient bits shift in at the bottom as numerator bits leave the top.
		always_ff @(posedge clk) begin
			rem_s[i]  <= take ? DEN_W'(trial - {1'b0, p_den}) : trial[DEN_W-1:0];
			wrk_s[i]  <= {p_wrk[NUM_W-2:0], take};
			den_s[i]  <= p_den;
			side_s[i] <= p_side;
		end
	end

	assign out_valid = vld_s[NUM_W-1];
	assign out_quo   = wrk_s[NUM_W-1];
	assign out_side  = side_s[NUM_W-1];

endmodule

// ===== design/ldt_log.sv =====
// ---------------------------------------------------------------------------
// ldt_log
// Pipelined natural log of a fixed-point value of at least 1.0: staged
// normalization, one squaring step per stage, then scaling by ln(2).
// ---------------------------------------------------------------------------
module ldt_log import ldt_pkg::*; #(
	parameter int FRACTION_BITS = FRACTION_BITS_DEF,
	parameter int SIDE_W        = 1
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	input  logic [32+FRACTION_BITS-1:0] in_x,
	input  logic [SIDE_W-1:0]          in_side,
	output logic                       out_valid,
	output logic [FRACTION_BITS+4:0]   out_ln,
	output logic [SIDE_W-1:0]          out_side
);

	localparam int XW     = 32 + FRACTION_BITS;
	localparam int NS     = $clog2(XW);
	localparam int LN_W   = FRACTION_BITS + 5;
	localparam int EXP_W  = 5;
	localparam int M_W    = 31;
	localparam int FR_W   = LOG_STEPS;
	localparam int L2_W   = EXP_W + FR_W - 8;
	localparam int PROD_W = L2_W + 32;
	localparam int LN_LSB = 56 - FRACTION_BITS;
	localparam logic [NS-1:0] EMAX = NS'(XW - 1 - FRACTION_BITS);

	// Normalizer stages.
	logic              nvld_s  [NS];
	logic [XW-1:0]     nx_s    [NS];
	logic [NS-1:0]     lz_s    [NS];
	logic [SIDE_W-1:0] nside_s [NS];

	// Squaring stages.
	logic              svld_s  [LOG_STEPS];
	logic [M_W-1:0]    m_s     [LOG_STEPS];
	logic [FR_W-1:0]   fr_s    [LOG_STEPS];
	logic [EXP_W-1:0]  ef_s    [LOG_STEPS];
	logic [SIDE_W-1:0] sside_s [LOG_STEPS];

	// Scaling stage.
	logic              pvld_q;
	logic [PROD_W-1:0] prod_q;
	logic [SIDE_W-1:0] pside_q;
	logic [L2_W-1:0]   l2_sc;

	// Shift left by halving amounts while the top bits are zero.
	for (genvar j = 0; j < NS; j++) begin : g_norm
		localparam int SH = 1 << (NS - 1 - j);
		logic              p_vld;
		logic [XW-1:0]     p_x;
		logic [NS-1:0]     p_lz;
		logic [SIDE_W-1:0] p_side;
		logic              zero_top;

		if (j == 0) begin : g_first
			assign p_vld  = in_valid;
			assign p_x    = in_x;
			assign p_lz   = '0;
			assign p_side = in_side;
		end else begin : g_next
			assign p_vld  = nvld_s[j-1];
			assign p_x    = nx_s[j-1];
			assign p_lz   = lz_s[j-1];
			assign p_side = nside_s[j-1];
		end

		assign zero_top = (p_x[XW-1 -: SH] == '0);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				nvld_s[j] <= 1'b0;
			end else begin
				nvld_s[j] <= p_vld;
			end
		end

		always_ff @(posedge clk) begin
			nx_s[j]    <= zero_top ? (p_x << SH) : p_x;
			lz_s[j]    <= zero_top ? (p_lz | NS'(SH)) : p_lz;
			nside_s[j] <= p_side;
		end
	end

	// Square the mantissa once per stage; an overflow past 2.0 yields a one bit.
	for (genvar k = 0; k < LOG_STEPS; k++) begin : g_sq
		logic              p_vld;
		logic [M_W-1:0]    p_m;
		logic [FR_W-1:0]   p_fr;
		logic [EXP_W-1:0]  p_ef;
		logic [SIDE_W-1:0] p_side;
		logic [2*M_W-1:0]  sq;
		logic [M_W:0]      sq_hi;

		if (k == 0) begin : g_first
			assign p_vld  = nvld_s[NS-1];
			assign p_m    = nx_s[NS-1][XW-1 -: M_W];
			assign p_fr   = '0;
			assign p_ef   = EXP_W'(EMAX - lz_s[NS-1]);
			assign p_side = nside_s[NS-1];
		end else begin : g_next
			assign p_vld  = svld_s[k-1];
			assign p_m    = m_s[k-1];
			assign p_fr   = fr_s[k-1];
			assign p_ef   = ef_s[k-1];
			assign p_side = sside_s[k-1];
		end

		assign sq    = p_m * p_m;
		assign sq_hi = sq[2*M_W-1:M_W-1];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				svld_s[k] <= 1'b0;
			end else begin
				svld_s[k] <= p_vld;
			end
		end

		always_ff @(posedge clk) begin
			m_s[k]     <= sq_hi[M_W] ? sq_hi[M_W:1] : sq_hi[M_W-1:0];
			fr_s[k]    <= {p_fr[FR_W-2:0], sq_hi[M_W]};
			ef_s[k]    <= p_ef;
			sside_s[k] <= p_side;
		end
	end

	// log2 truncated to 24 fraction bits, then scaled by ln(2).
	assign l2_sc = {ef_s[LOG_STEPS-1], fr_s[LOG_STEPS-1][FR_W-1:8]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pvld_q <= 1'b0;
		end else begin
			pvld_q <= svld_s[LOG_STEPS-1];
		end
	end

	always_ff @(posedge clk) begin
		prod_q  <= PROD_W'(l2_sc) * PROD_W'(LN2_Q32);
		pside_q <= sside_s[LOG_STEPS-1];
	end

	assign out_valid = pvld_q;
	assign out_ln    = prod_q[LN_LSB +: LN_W];
	assign out_side  = pside_q;

endmodule

// ===== design/landsat_dn_to_toa_unit.sv =====
// ---------------------------------------------------------------------------
// landsat_dn_to_toa_unit
// Converts a calibrated digital number to radiance and to top-of-atmosphere
// reflectance or brightness temperature in signed fixed point.
// ---------------------------------------------------------------------------
// Usage:
// A request is taken on each rising edge with start high and busy low; busy
// stays low, so one pixel can enter every cycle. Each request produces one
// result on radiance, converted_value and status, shown for exactly one cycle
// with done high, in request order.
// A request passes the radiance stages, the first divider (32 + FRACTION_BITS
// stages), the log unit (normalizer, 32 squaring stages, ln(2) scaling), the
// second divider (31 + FRACTION_BITS stages) and the formatting stages.
// Throughput is one result per cycle.
// The coefficient registers are written through cfg_write, cfg_index and
// cfg_data; the user must write them only while no request is in flight, as
// the block does not enforce it. They take effect at once. Reset clears all
// pipeline valid bits and loads gain 1.0, bias 0, k_one 0, k_two 1.0 and
// reflective mode. The receiver cannot stall the results.
// ---------------------------------------------------------------------------
module landsat_dn_to_toa_unit import ldt_pkg::*; #(
	parameter int DN_BITS       = DN_BITS_DEF,
	parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [15:0]        digital_number,
	input  logic               cfg_write,
	input  logic [IDX_W-1:0]   cfg_index,
	input  logic [CFG_W-1:0]   cfg_data,
	output logic               done,
	output logic signed [31:0] radiance,
	output logic signed [31:0] converted_value,
	output logic [1:0]         status
);

	localparam int NUM1_W = 32 + FRACTION_BITS;
	localparam int NUM2_W = K_W + FRACTION_BITS;
	localparam int LN_W   = FRACTION_BITS + 5;
	localparam int PROD_W = DN_BITS + 33;
	localparam int SUM_W  = DN_BITS + 34;

	// Coefficient registers.
	logic signed [31:0] gain_q;
	logic signed [31:0] bias_q;
	logic [K_W-1:0]     k_one_q;
	logic [K_W-1:0]     k_two_q;
	logic               mode_q;

	// Radiance stages.
	logic                     vld_s1;
	logic signed [PROD_W-1:0] prod_s1;
	logic signed [SUM_W-1:0]  sum;
	logic                     sum_fits;
	logic signed [31:0]       rad_sat;
	logic                     vld_s2;
	logic signed [31:0]       rad_s2;

	// First divider.
	logic               rad_neg;
	logic [31:0]        rad_mag;
	logic [NUM1_W-1:0]  num1;
	logic [K_W-1:0]     den1;
	div1_side_t         side1;
	logic               q1_vld;
	logic [NUM1_W-1:0]  q1;
	div1_side_t         d1_out;

	// Reflectance and log argument stage.
	logic               q1_big;
	logic signed [31:0] refl;
	logic               vld_s3;
	logic [NUM1_W-1:0]  x_s3;
	log_side_t          side_s3;

	// Log unit and second divider.
	logic               ln_vld;
	logic [LN_W-1:0]    ln_val;
	log_side_t          ln_side;
	div2_side_t         side2;
	logic               t_vld;
	logic [NUM2_W-1:0]  t_quo;
	div2_side_t         d2_out;
	logic signed [31:0] temp_sat;
	logic signed [31:0] value_sel;

	// Output registers.
	logic               done_q;
	logic signed [31:0] radiance_q;
	logic signed [31:0] value_q;
	status_t            status_q;

	assign busy = 1'b0;

	// Register writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q  <= 32'sd1 <<< FRACTION_BITS;
			bias_q  <= '0;
			k_one_q <= '0;
			k_two_q <= K_W'(1) << FRACTION_BITS;
			mode_q  <= 1'b0;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_GAIN:  gain_q  <= cfg_data;
				REG_BIAS:  bias_q  <= cfg_data;
				REG_K_ONE: k_one_q <= cfg_data[K_W-1:0];
				REG_K_TWO: k_two_q <= cfg_data[K_W-1:0];
				REG_MODE:  mode_q  <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	// Valid bits of the top-level stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			done_q <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
			vld_s2 <= vld_s1;
			vld_s3 <= q1_vld;
			done_q <= t_vld;
		end
	end

	// Stage 1: digital number times gain.
	always_ff @(posedge clk) begin
		prod_s1 <= $signed({1'b0, digital_number[DN_BITS-1:0]}) * gain_q;
	end

	// Stage 2: add bias and saturate to 32 bits.
	assign sum      = SUM_W'(prod_s1) + SUM_W'(bias_q);
	assign sum_fits = (sum[SUM_W-1:31] == '0) || (sum[SUM_W-1:31] == '1);
	assign rad_sat  = sum_fits ? sum[31:0] : (sum[SUM_W-1] ? SAT_MIN : SAT_MAX);

	always_ff @(posedge clk) begin
		rad_s2 <= rad_sat;
	end

	// First division: reflectance magnitude, or k_one over radiance in thermal.
	assign rad_neg = rad_s2[31];
	assign rad_mag = rad_neg ? (~rad_s2 + 32'd1) : rad_s2;

	always_comb begin
		if (mode_q) begin
			num1         = {1'b0, k_one_q, {FRACTION_BITS{1'b0}}};
			den1         = rad_s2[K_W-1:0];
			side1.status = (rad_neg || rad_s2 == '0) ? STATUS_NONPOS : STATUS_OK;
		end else begin
			num1         = {rad_mag, {FRACTION_BITS{1'b0}}};
			den1         = k_two_q;
			side1.status = (k_two_q == '0) ? STATUS_ZERO_DIV : STATUS_OK;
		end
		side1.rad = rad_s2;
		side1.neg = rad_neg;
	end

	ldt_div #(
		.NUM_W (NUM1_W),
		.DEN_W (K_W),
		.SIDE_W($bits(div1_side_t))
	) u_div_q (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (vld_s2),
		.in_num   (num1),
		.in_den   (den1),
		.in_side  (side1),
		.out_valid(q1_vld),
		.out_quo  (q1),
		.out_side (d1_out)
	);

	// Stage 3: signed, saturated reflectance and the log argument q + 1.0.
	assign q1_big = |q1[NUM1_W-1:32];

	always_comb begin
		if (!d1_out.neg) begin
			refl = (q1_big || q1[31]) ? SAT_MAX : {1'b0, q1[30:0]};
		end else begin
			refl = (q1_big || (q1[31] && |q1[30:0])) ? SAT_MIN : (~q1[31:0] + 32'd1);
		end
	end

	always_ff @(posedge clk) begin
		x_s3           <= q1 + (NUM1_W'(1) << FRACTION_BITS);
		side_s3.rad    <= d1_out.rad;
		side_s3.status <= d1_out.status;
		side_s3.refl   <= refl;
	end

	ldt_log #(
		.FRACTION_BITS(FRACTION_BITS),
		.SIDE_W       ($bits(log_side_t))
	) u_log (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (vld_s3),
		.in_x     (x_s3),
		.in_side  (side_s3),
		.out_valid(ln_vld),
		.out_ln   (ln_val),
		.out_side (ln_side)
	);

	// Second division: k_two over the log gives the temperature.
	assign side2.base    = ln_side;
	assign side2.ln_zero = (ln_val == '0);

	ldt_div #(
		.NUM_W (NUM2_W),
		.DEN_W (LN_W),
		.SIDE_W($bits(div2_side_t))
	) u_div_t (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (ln_vld),
		.in_num   ({k_two_q, {FRACTION_BITS{1'b0}}}),
		.in_den   (ln_val),
		.in_side  (side2),
		.out_valid(t_vld),
		.out_quo  (t_quo),
		.out_side (d2_out)
	);

	// Final selection by mode and error status.
	assign temp_sat = (|t_quo[NUM2_W-1:31]) ? SAT_MAX : {1'b0, t_quo[30:0]};

	always_comb begin
		if (mode_q) begin
			if (d2_out.base.status == STATUS_NONPOS) begin
				value_sel = '0;
			end else if (d2_out.ln_zero) begin
				value_sel = (k_two_q != '0) ? SAT_MAX : '0;
			end else begin
				value_sel = temp_sat;
			end
		end else begin
			value_sel = (d2_out.base.status == STATUS_ZERO_DIV) ? '0 : d2_out.base.refl;
		end
	end

	always_ff @(posedge clk) begin
		radiance_q <= d2_out.base.rad;
		value_q    <= value_sel;
		status_q   <= d2_out.base.status;
	end

	assign done            = done_q;
	assign radiance        = radiance_q;
	assign converted_value = value_q;
	assign status          = status_q;

endmodule

// ===== design/ldt_chk.sv =====
// ---------------------------------------------------------------------------
// ldt_chk
// Port-level checks of the TOA conversion unit, bound to the top level.
// ---------------------------------------------------------------------------
`include "landsat_dn_to_toa_unit_macros.svh"

module ldt_chk import ldt_pkg::*; #(
	parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
	input logic               clk,
	input logic               arst_n,
	input logic               start,
	input logic               busy,
	input logic               done,
	input logic signed [31:0] converted_value,
	input logic [1:0]         status
);

	localparam int LATENCY = ldt_latency(FRACTION_BITS);

	// Every accepted request completes after the fixed latency.
	`LDT_ASSERT_DLY(a_latency, start && !busy, LATENCY, done, "Request did not complete on time")

	// No result appears without a request the fixed latency earlier.
	`LDT_ASSERT_IMP(a_no_phantom, done, $past(start && !busy, LATENCY), "Result without a request")

	// An error result carries a zero value.
	`LDT_ASSERT_IMP(a_err_zero, done && (status == STATUS_NONPOS || status == STATUS_ZERO_DIV), converted_value == '0, "Error result with nonzero value")

endmodule

bind landsat_dn_to_toa_unit ldt_chk #(.FRACTION_BITS(FRACTION_BITS)) u_ldt_chk (.*);
